/* sv/pddvc_pkg.sv */
// shared types, constants and helpers for the polyline delta decoder with viewport cull
package pddvc_pkg;

	localparam int COORD_W          = 32;
	localparam int COUNT_W          = 16;
	localparam int VARINT_MAX_BYTES = 5;
	localparam int COORD_SHIFT_DEF  = 5;
	localparam int QUEUE_DEPTH_DEF  = 4;
	localparam int ADDR_W           = 5;
	localparam int DATA_W           = 32;

	// sticky byte-count code marking a malformed object
	localparam logic [2:0] NB_BAD = 3'd7;

	typedef enum logic [2:0] {
		REG_QUERY_LEFT   = 3'd0,
		REG_QUERY_RIGHT  = 3'd1,
		REG_QUERY_TOP    = 3'd2,
		REG_QUERY_BOTTOM = 3'd3,
		REG_ORIGIN_X     = 3'd4,
		REG_ORIGIN_Y     = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		VERDICT_HIDDEN    = 2'd0,
		VERDICT_VISIBLE   = 2'd1,
		VERDICT_MALFORMED = 2'd2
	} verdict_t;

	// one queue entry: a decoded value and/or an end-of-object mark
	typedef struct packed {
		logic               bad;
		logic               last;
		logic               has_value;
		logic [COORD_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] bottom;
	} query_t;

	// bit position of the 7-bit group for a given byte count
	function automatic logic [4:0] group_shift(input logic [2:0] nb);
		logic [4:0] sh;
		case (nb)
			3'd0:    sh = 5'd0;
			3'd1:    sh = 5'd7;
			3'd2:    sh = 5'd14;
			3'd3:    sh = 5'd21;
			3'd4:    sh = 5'd28;
			default: sh = 5'd0;
		endcase
		return sh;
	endfunction

	// undo the zigzag sign mapping
	function automatic logic [COORD_W-1:0] unzigzag(input logic [COORD_W-1:0] a);
		return (a >> 1) ^ {COORD_W{a[0]}};
	endfunction

endpackage

/* sv/pddvc_front.sv */
// front end: varint byte assembly, zigzag decode and fault classification
module pddvc_front import pddvc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       take,
	output logic       push,
	output entry_t     entry
);

	logic [COORD_W-1:0] acc_q, acc_or, acc_nx;
	logic [2:0]         nb_q, nb_step, nb_nx;
	logic               done;

	// merge the byte into the partial value and work out the next count
	always_comb begin
		acc_or  = acc_q | (COORD_W'({data_byte[6:0]}) << group_shift(nb_q));
		done    = 1'b0;
		nb_step = nb_q;
		acc_nx  = acc_q;
		if (nb_q != NB_BAD) begin
			acc_nx = acc_or;
			if (data_byte[7]) begin
				nb_step = (3'(nb_q + 3'd1) >= 3'(VARINT_MAX_BYTES)) ? NB_BAD : 3'(nb_q + 3'd1);
			end else begin
				done    = 1'b1;
				nb_step = 3'd0;
				acc_nx  = '0;
			end
		end
		nb_nx = nb_step;
		if (last_byte) begin
			nb_nx  = 3'd0;
			acc_nx = '0;
		end
	end

	// entry towards the queue
	always_comb begin
		entry.value     = unzigzag(acc_or);
		entry.has_value = done;
		entry.last      = last_byte;
		entry.bad       = (nb_step != 3'd0);
		push            = take && (done || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			nb_q  <= 3'd0;
		end else if (take) begin
			acc_q <= acc_nx;
			nb_q  <= nb_nx;
		end
	end

endmodule

/* sv/pddvc_queue.sv */
// short first-in first-out queue between the front and back ends
module pddvc_queue import pddvc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  entry_t                     push_data,
	input  logic                       pop,
	output entry_t                     pop_data,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign count    = cnt_q;
	assign pop_data = slot_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= CNT_W'(cnt_q + 1'b1);
				2'b01:   cnt_q <= CNT_W'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/pddvc_back.sv */
// back end: x/y pairing, point accumulation, rectangle test, box tracking and verdict
module pddvc_back import pddvc_pkg::*; #(
	parameter int COORD_SHIFT = COORD_SHIFT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  query_t             query,
	input  logic [COORD_W-1:0] origin_x,
	input  logic [COORD_W-1:0] origin_y,
	input  entry_t             entry,
	input  logic               avail,
	output logic               pop,
	output logic               out_valid,
	output verdict_t           out_verdict,
	output logic [COUNT_W-1:0] out_total,
	input  logic               out_ready
);

	localparam logic [COORD_W-1:0] ORIGIN_MASK = ~((COORD_W'(1) << COORD_SHIFT) - COORD_W'(1));
	localparam logic [COORD_W-1:0] BOX_MIN_INIT = {1'b0, {(COORD_W-1){1'b1}}};

	logic adv;

	// pairing state
	logic               open_q, expect_q;
	logic [COORD_W-1:0] pending_q, prev_x_q, prev_y_q;
	logic [COORD_W-1:0] prev_x_use, prev_y_use, x_new, y_new;
	logic               make_point, expect_nx;

	// stage 1
	logic               v_s1, pt_s1, last_s1, bad_s1;
	logic [COORD_W-1:0] x_s1, y_s1;

	// accumulation state
	logic               inside_q, inside_nx, in_rect, widen;
	logic [COORD_W-1:0] minx_q, maxx_q, miny_q, maxy_q;
	logic [COORD_W-1:0] minx_nx, maxx_nx, miny_nx, maxy_nx;
	logic [COUNT_W-1:0] cnt_q, cnt_nx;

	// stage 2 snapshot of a finished object
	logic               res_s2, bad_s2, inside_s2;
	logic [COORD_W-1:0] minx_s2, maxx_s2, miny_s2, maxy_s2;
	logic [COUNT_W-1:0] cnt_s2;
	logic               overlap;
	verdict_t           verdict_c;

	// output register
	logic               out_valid_q;
	verdict_t           verdict_q;
	logic [COUNT_W-1:0] total_q;

	// whole back end moves together unless a result waits unclaimed
	assign adv = !(out_valid_q && !out_ready);
	assign pop = adv && avail;

	// pairing of x and y values into points
	always_comb begin
		prev_x_use = open_q ? prev_x_q : (origin_x & ORIGIN_MASK);
		prev_y_use = open_q ? prev_y_q : (origin_y & ORIGIN_MASK);
		x_new      = COORD_W'((pending_q << COORD_SHIFT) + prev_x_use);
		y_new      = COORD_W'((entry.value << COORD_SHIFT) + prev_y_use);
		make_point = entry.has_value && expect_q;
		expect_nx  = entry.has_value ? !expect_q : expect_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			expect_q <= 1'b0;
		end else if (pop) begin
			open_q   <= !entry.last;
			expect_q <= entry.last ? 1'b0 : expect_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (entry.has_value && !expect_q) begin
				pending_q <= entry.value;
			end
			prev_x_q <= make_point ? x_new : prev_x_use;
			prev_y_q <= make_point ? y_new : prev_y_use;
		end
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pt_s1   <= make_point;
			last_s1 <= entry.last;
			bad_s1  <= entry.bad || expect_nx;
			x_s1    <= x_new;
			y_s1    <= y_new;
		end
	end

	// rectangle test, box widening and point count
	always_comb begin
		in_rect = ($signed(query.left) <= $signed(x_s1)) && ($signed(x_s1) <= $signed(query.right))
			&& ($signed(query.top) <= $signed(y_s1)) && ($signed(y_s1) <= $signed(query.bottom));
		inside_nx = inside_q || (pt_s1 && in_rect);
		widen     = pt_s1 && !inside_nx;
		minx_nx   = (widen && ($signed(x_s1) <= $signed(minx_q))) ? x_s1 : minx_q;
		maxx_nx   = (widen && ($signed(maxx_q) <= $signed(x_s1))) ? x_s1 : maxx_q;
		miny_nx   = (widen && ($signed(y_s1) <= $signed(miny_q))) ? y_s1 : miny_q;
		maxy_nx   = (widen && ($signed(maxy_q) <= $signed(y_s1))) ? y_s1 : maxy_q;
		cnt_nx    = (pt_s1 && (cnt_q != '1)) ? COUNT_W'(cnt_q + 1'b1) : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			minx_q   <= BOX_MIN_INIT;
			maxx_q   <= '0;
			miny_q   <= BOX_MIN_INIT;
			maxy_q   <= '0;
			cnt_q    <= '0;
			res_s2   <= 1'b0;
		end else if (adv) begin
			res_s2 <= v_s1 && last_s1;
			if (v_s1) begin
				if (last_s1) begin
					inside_q <= 1'b0;
					minx_q   <= BOX_MIN_INIT;
					maxx_q   <= '0;
					miny_q   <= BOX_MIN_INIT;
					maxy_q   <= '0;
					cnt_q    <= '0;
				end else begin
					inside_q <= inside_nx;
					minx_q   <= minx_nx;
					maxx_q   <= maxx_nx;
					miny_q   <= miny_nx;
					maxy_q   <= maxy_nx;
					cnt_q    <= cnt_nx;
				end
			end
		end
	end

	// snapshot of the finished object
	always_ff @(posedge clk) begin
		if (adv && v_s1 && last_s1) begin
			bad_s2    <= bad_s1;
			inside_s2 <= inside_nx;
			minx_s2   <= minx_nx;
			maxx_s2   <= maxx_nx;
			miny_s2   <= miny_nx;
			maxy_s2   <= maxy_nx;
			cnt_s2    <= cnt_nx;
		end
	end

	// final verdict from the snapshot
	always_comb begin
		overlap = ($signed(query.left) <= $signed(maxx_s2))
			&& ($signed(minx_s2) <= $signed(query.right))
			&& ($signed(miny_s2) <= $signed(query.bottom))
			&& ($signed(query.top) <= $signed(maxy_s2));
		if (bad_s2) begin
			verdict_c = VERDICT_MALFORMED;
		end else if (inside_s2 || overlap) begin
			verdict_c = VERDICT_VISIBLE;
		end else begin
			verdict_c = VERDICT_HIDDEN;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_s2) begin
			verdict_q <= verdict_c;
			total_q   <= cnt_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_verdict = verdict_q;
	assign out_total   = total_q;

endmodule

/* sv/polyline_delta_decode_viewport_cull.sv */
// top level: configuration registers, front end, queue, back end and stream ports
// Takes one encoded byte per cycle, sustained, for as long as the result side keeps up:
// the front end assembles base-128 varints and hands decoded values (and the end-of-object
// mark) to a QUEUE_DEPTH-entry queue, so the byte side is held off only when that queue is
// full. The back end pairs values into points, tests each point against the query rectangle
// and widens the bounding box, one queue entry per cycle, and delivers one result per object
// once its last byte has passed the queue, pairing stage, accumulation stage and output register.
// While a finished result waits unclaimed the whole back end holds, and the byte side runs on
// only until the queue fills. The query registers are read live; origin_x/origin_y are
// sampled when the back end takes the first queue entry of each object.
// There is no clearing pass after reset.
module polyline_delta_decode_viewport_cull import pddvc_pkg::*; #(
	parameter int COORD_SHIFT = COORD_SHIFT_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// byte input
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,  // [7:0] data_byte
	input  logic              s_tlast,  // last_byte
	// result output
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata   // [1:0] verdict, [17:2] point_total, [23:18] zero
);

	query_t                         query_q;
	logic [COORD_W-1:0]             origin_x_q, origin_y_q;
	logic                           cfg_wr;
	reg_idx_t                       cfg_idx;

	logic                           take, q_push, q_pop, q_full, q_empty;
	entry_t                         q_in, q_out;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
	verdict_t                       verdict;
	logic [COUNT_W-1:0]             point_total;

	// register access
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q    <= '0;
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_QUERY_LEFT:   query_q.left   <= pwdata;
				REG_QUERY_RIGHT:  query_q.right  <= pwdata;
				REG_QUERY_TOP:    query_q.top    <= pwdata;
				REG_QUERY_BOTTOM: query_q.bottom <= pwdata;
				REG_ORIGIN_X:     origin_x_q     <= pwdata;
				REG_ORIGIN_Y:     origin_y_q     <= pwdata;
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_QUERY_LEFT:   prdata = query_q.left;
			REG_QUERY_RIGHT:  prdata = query_q.right;
			REG_QUERY_TOP:    prdata = query_q.top;
			REG_QUERY_BOTTOM: prdata = query_q.bottom;
			REG_ORIGIN_X:     prdata = origin_x_q;
			REG_ORIGIN_Y:     prdata = origin_y_q;
			default:          prdata = '0;
		endcase
	end

	// byte side handshake
	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	pddvc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (s_tdata),
		.last_byte (s_tlast),
		.take      (take),
		.push      (q_push),
		.entry     (q_in)
	);

	pddvc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.full      (q_full),
		.empty     (q_empty),
		.count     (q_count)
	);

	pddvc_back #(
		.COORD_SHIFT (COORD_SHIFT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.query       (query_q),
		.origin_x    (origin_x_q),
		.origin_y    (origin_y_q),
		.entry       (q_out),
		.avail       (!q_empty),
		.pop         (q_pop),
		.out_valid   (m_tvalid),
		.out_verdict (verdict),
		.out_total   (point_total),
		.out_ready   (m_tready)
	);

	// result packing
	assign m_tdata = {6'd0, point_total, verdict};

	// checks
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(q_full && !q_pop) |=> (q_count == $past(q_count)))
		else $error("queue count moved past its depth");

endmodule
